FILE: src/tnb_pkg.sv
// Shared constants for the triple notch biquad filter: field widths, fixed-point
// formats, configuration register indexes and reset values.
// Depends on nothing; used by tnb_mul, triple_notch_biquad_filter and tb_top.
package tnb_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int STATE_WIDTH_DEF  = 40;

  // Coefficients are signed Q2.16, three of them packed in one register.
  localparam int COEF_WIDTH   = 18;
  localparam int COEF_FRAC    = 16;
  localparam int NUM_SECTIONS = 3;
  localparam int SEC_WIDTH    = 2;

  localparam int GAIN_WIDTH = 16;
  localparam int GAIN_FRAC  = 11;
  localparam logic [GAIN_WIDTH-1:0] GAIN_RESET = 16'd2048;

  localparam int CFG_INDEX_WIDTH = 4;
  localparam int CFG_DATA_WIDTH  = 3 * COEF_WIDTH;

  localparam logic [CFG_INDEX_WIDTH-1:0] IDX_NOTCH1 = 4'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] IDX_NOTCH2 = 4'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] IDX_NOTCH3 = 4'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] IDX_GAIN   = 4'd3;

endpackage

FILE: src/tnb_mul.sv
// Shared coefficient multiplier of the notch filter, with a registered product.
// Depends on tnb_pkg for the coefficient width.
module tnb_mul #(
  parameter int STATE_WIDTH = tnb_pkg::STATE_WIDTH_DEF
) (
  input  logic                                                    clk,
  input  logic signed [tnb_pkg::COEF_WIDTH-1:0]                   coef,
  input  logic signed [STATE_WIDTH-1:0]                           operand,
  output logic signed [STATE_WIDTH+tnb_pkg::COEF_WIDTH-1:0]       product
);
  import tnb_pkg::*;

  localparam int PW = STATE_WIDTH + COEF_WIDTH;

  always_ff @(posedge clk) begin
    product <= PW'(coef) * PW'(operand);
  end

endmodule

FILE: src/triple_notch_biquad_filter.sv
// Top level of the triple notch biquad filter: configuration registers, section
// delays, sequencer and rounding adder around one shared multiplier.
// Depends on tnb_pkg and tnb_mul.
//
// Usage. Samples enter on the input channel (sample_in, in_valid, in_ready) and
// leave on the output channel (sample_out, out_valid, out_ready); both complete
// a transaction when valid and ready are high at a rising edge. The four
// configuration registers are written over the cfg channel, which is always
// ready; writes to an index above three are dropped. Write them only while the
// filter is idle.
// Each sample runs through three notch sections, each stepping through ST_Y,
// ST_B1, ST_A1 and ST_A2 on a single 18-bit by state-width multiplier, then
// through a step for the post gain and one for rounding and saturation. No
// new sample is taken until the result has gone into the output register;
// the shared multiplier is used ten times per sample.
// The output register holds a finished sample while the receiver stalls, and
// the filter still takes the next sample; that sample then waits in its final
// step until the output register is free.
// Reset clears all section delays and coefficients and sets the gain to unity.
module triple_notch_biquad_filter #(
  parameter int SAMPLE_WIDTH = tnb_pkg::SAMPLE_WIDTH_DEF,
  parameter int STATE_WIDTH  = tnb_pkg::STATE_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]         sample_in,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]         sample_out,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [tnb_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [tnb_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);
  import tnb_pkg::*;

  localparam int PW        = STATE_WIDTH + COEF_WIDTH;
  localparam int AW        = STATE_WIDTH + 4;
  localparam int IN_ALIGN  = STATE_WIDTH - 8 - (SAMPLE_WIDTH - 1);
  localparam int OUT_SHIFT = GAIN_FRAC + STATE_WIDTH - 8 - (SAMPLE_WIDTH - 1);
  localparam int GW        = PW - OUT_SHIFT + 1;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_Y    = 7'b0000010,
    ST_B1   = 7'b0000100,
    ST_A1   = 7'b0001000,
    ST_A2   = 7'b0010000,
    ST_GAIN = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  state_t                   state;
  state_t                   state_next;
  logic [SEC_WIDTH-1:0]     sec;
  logic [CFG_DATA_WIDTH-1:0] notch [NUM_SECTIONS];
  logic [GAIN_WIDTH-1:0]    post_gain;
  logic signed [STATE_WIDTH-1:0] s1 [NUM_SECTIONS];
  logic signed [STATE_WIDTH-1:0] s2 [NUM_SECTIONS];
  logic signed [STATE_WIDTH-1:0] xreg;
  logic signed [STATE_WIDTH-1:0] yreg;
  logic signed [AW-1:0]          acc;

  logic signed [STATE_WIDTH-1:0] x_in;
  logic [CFG_DATA_WIDTH-1:0]     notch_sel;
  logic signed [COEF_WIDTH-1:0]  b1;
  logic signed [COEF_WIDTH-1:0]  a1;
  logic signed [COEF_WIDTH-1:0]  a2;
  logic signed [COEF_WIDTH-1:0]  mul_coef;
  logic signed [STATE_WIDTH-1:0] mul_op;
  logic signed [PW-1:0]          product;

  logic signed [AW-1:0] p_ext;
  logic                 p_rb;
  logic signed [AW-1:0] x_ext;
  logic signed [AW-1:0] y_sum;
  logic signed [AW-1:0] b1_sum;
  logic signed [AW-1:0] n1_sum;
  logic signed [AW-1:0] n2_sum;
  logic signed [GW-1:0] g_sum;
  logic signed [SAMPLE_WIDTH-1:0] g_sat;
  logic                 out_free;

  function automatic logic signed [STATE_WIDTH-1:0] sat_state(input logic signed [AW-1:0] v);
    logic [AW-STATE_WIDTH:0] top;
    top = v[AW-1:STATE_WIDTH-1];
    if (top == '0 || top == '1) begin
      return v[STATE_WIDTH-1:0];
    end else if (v[AW-1]) begin
      return {1'b1, {(STATE_WIDTH-1){1'b0}}};
    end else begin
      return {1'b0, {(STATE_WIDTH-1){1'b1}}};
    end
  endfunction

  // Move the sample into the state format; a narrow state rounds half up.
  generate
    if (IN_ALIGN >= 0) begin : g_align_left
      assign x_in = STATE_WIDTH'($signed(sample_in)) <<< IN_ALIGN;
    end else begin : g_align_right
      localparam int K = -IN_ALIGN;
      logic signed [SAMPLE_WIDTH:0] rnd_in;
      assign rnd_in = (SAMPLE_WIDTH+1)'($signed(sample_in)) + (SAMPLE_WIDTH+1)'(1 << (K - 1));
      assign x_in = STATE_WIDTH'(rnd_in >>> K);
    end
  endgenerate

  assign notch_sel = notch[sec];
  assign b1 = $signed(notch_sel[COEF_WIDTH-1:0]);
  assign a1 = $signed(notch_sel[2*COEF_WIDTH-1:COEF_WIDTH]);
  assign a2 = $signed(notch_sel[3*COEF_WIDTH-1:2*COEF_WIDTH]);

  always_comb begin
    case (state)
      ST_Y: begin
        mul_coef = b1;
        mul_op   = xreg;
      end
      ST_B1: begin
        mul_coef = a1;
        mul_op   = yreg;
      end
      ST_A1: begin
        mul_coef = a2;
        mul_op   = yreg;
      end
      default: begin
        mul_coef = $signed({2'b00, post_gain});
        mul_op   = xreg;
      end
    endcase
  end

  tnb_mul #(
    .STATE_WIDTH(STATE_WIDTH)
  ) u_mul (
    .clk    (clk),
    .coef   (mul_coef),
    .operand(mul_op),
    .product(product)
  );

  // Round half up is the truncated product plus its first dropped bit; for a
  // subtraction that bit folds into the carry of the two's complement.
  assign p_ext  = AW'($signed(product[PW-1:COEF_FRAC]));
  assign p_rb   = product[COEF_FRAC-1];
  assign x_ext  = AW'(xreg);
  assign y_sum  = x_ext + AW'(s1[sec]);
  assign b1_sum = p_ext + AW'(s2[sec]) + AW'(p_rb);
  assign n1_sum = acc + ~p_ext + AW'(!p_rb);
  assign n2_sum = x_ext + ~p_ext + AW'(!p_rb);
  assign g_sum  = GW'($signed(product[PW-1:OUT_SHIFT])) + GW'(product[OUT_SHIFT-1]);

  always_comb begin
    logic [GW-SAMPLE_WIDTH:0] gtop;
    gtop = g_sum[GW-1:SAMPLE_WIDTH-1];
    if (gtop == '0 || gtop == '1) begin
      g_sat = g_sum[SAMPLE_WIDTH-1:0];
    end else if (g_sum[GW-1]) begin
      g_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      g_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
  end

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_Y;
        end
      end
      ST_Y:  state_next = ST_B1;
      ST_B1: state_next = ST_A1;
      ST_A1: state_next = ST_A2;
      ST_A2: begin
        if (sec == SEC_WIDTH'(NUM_SECTIONS - 1)) begin
          state_next = ST_GAIN;
        end else begin
          state_next = ST_Y;
        end
      end
      ST_GAIN: state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sec       <= '0;
      out_valid <= 1'b0;
      post_gain <= GAIN_RESET;
      for (int i = 0; i < NUM_SECTIONS; i++) begin
        notch[i] <= '0;
        s1[i]    <= '0;
        s2[i]    <= '0;
      end
    end else begin
      state <= state_next;

      if (cfg_valid) begin
        case (cfg_index)
          IDX_NOTCH1: notch[0] <= cfg_data;
          IDX_NOTCH2: notch[1] <= cfg_data;
          IDX_NOTCH3: notch[2] <= cfg_data;
          IDX_GAIN:   post_gain <= cfg_data[GAIN_WIDTH-1:0];
          default:    ;
        endcase
      end

      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            xreg <= x_in;
            sec  <= '0;
          end
        end
        ST_Y: begin
          yreg <= sat_state(y_sum);
        end
        ST_B1: begin
          acc <= b1_sum;
        end
        ST_A1: begin
          s1[sec] <= sat_state(n1_sum);
        end
        ST_A2: begin
          s2[sec] <= sat_state(n2_sum);
          xreg    <= yreg;
          if (sec != SEC_WIDTH'(NUM_SECTIONS - 1)) begin
            sec <= sec + 1'b1;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            sample_out <= g_sat;
          end
        end
        default: ;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_Y && sec == '0)
    else $error("accepted sample did not start the first section");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_OUT)
    else $error("result raised outside the output step");

  a_last_section: assert property (@(posedge clk) disable iff (rst)
    state == ST_A2 && sec == SEC_WIDTH'(NUM_SECTIONS - 1) |=> state == ST_GAIN)
    else $error("sequencer skipped the post gain after the last section");

  a_sec_range: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> sec < SEC_WIDTH'(NUM_SECTIONS))
    else $error("section counter out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out))
    else $error("waiting result was overwritten");

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for triple_notch_biquad_filter: random and corner samples
// are checked against an in-bench fixed-point model of the three notch sections.
// Depends on tnb_pkg and the filter RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tnb_pkg::*;

  localparam int SAMPLE_BITS = SAMPLE_WIDTH_DEF;
  localparam int STATE_BITS  = STATE_WIDTH_DEF;
  localparam int STATE_FRAC  = STATE_BITS - 8;
  localparam int IN_SHIFT    = STATE_FRAC - (SAMPLE_BITS - 1);
  localparam int OUT_SHIFT   = GAIN_FRAC + STATE_FRAC - (SAMPLE_BITS - 1);
  localparam longint STATE_MAX  = (longint'(1) <<< (STATE_BITS - 1)) - 1;
  localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam int COEF_MAX = (1 << (COEF_WIDTH - 1)) - 1;
  localparam int COEF_MIN = -(1 << (COEF_WIDTH - 1));

  localparam logic [CFG_INDEX_WIDTH-1:0] IDX_SPARE_FIRST = 4'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] IDX_SPARE_LAST  = 4'd15;

  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_SAMPLES = 135;
  localparam int MAX_REPORTS   = 10;

  localparam logic [SAMPLE_BITS-1:0] CORNER_SAMPLES [13] = '{
    16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h0000, 16'h0000,
    16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h5555, 16'hAAAA
  };
  localparam logic [SAMPLE_BITS-1:0] OVERLOAD_SAMPLES [12] = '{
    16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
    16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0001, 16'hFFFF
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SAMPLE_BITS-1:0] sample_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

  // Shadow of the filter's registers and section delays.
  logic [CFG_DATA_WIDTH-1:0] notch_coef [NUM_SECTIONS] = '{default: '0};
  logic [GAIN_WIDTH-1:0] gain_shadow = GAIN_RESET;
  longint delay_one [NUM_SECTIONS] = '{default: 0};
  longint delay_two [NUM_SECTIONS] = '{default: 0};

  logic signed [SAMPLE_BITS-1:0] pending_samples [$];
  logic signed [SAMPLE_BITS-1:0] expected_samples [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int result_count = 0;
  int cycle_count = 0;

  triple_notch_biquad_filter u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint saturate(longint v, longint hi);
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Product rounded half up after dropping sh fraction bits.
  function automatic longint scaled_product(longint c, longint v, int sh);
    return (c * v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] filter_sample(
      logic signed [SAMPLE_BITS-1:0] s);
    longint x, y, b1, a1, a2, g;
    x = s;
    x = saturate(x <<< IN_SHIFT, STATE_MAX);
    for (int i = 0; i < NUM_SECTIONS; i++) begin
      b1 = $signed(notch_coef[i][COEF_WIDTH-1:0]);
      a1 = $signed(notch_coef[i][2*COEF_WIDTH-1:COEF_WIDTH]);
      a2 = $signed(notch_coef[i][3*COEF_WIDTH-1:2*COEF_WIDTH]);
      y = saturate(x + delay_one[i], STATE_MAX);
      delay_one[i] = saturate(scaled_product(b1, x, COEF_FRAC)
                              - scaled_product(a1, y, COEF_FRAC) + delay_two[i], STATE_MAX);
      delay_two[i] = saturate(x - scaled_product(a2, y, COEF_FRAC), STATE_MAX);
      x = y;
    end
    g = saturate(scaled_product(longint'(gain_shadow), x, OUT_SHIFT), SAMPLE_MAX);
    return g[SAMPLE_BITS-1:0];
  endfunction

  function automatic logic [CFG_DATA_WIDTH-1:0] pack_notch(int b1, int a1, int a2);
    logic [COEF_WIDTH-1:0] fb, fa1, fa2;
    fb  = b1[COEF_WIDTH-1:0];
    fa1 = a1[COEF_WIDTH-1:0];
    fa2 = a2[COEF_WIDTH-1:0];
    return {fa2, fa1, fb};
  endfunction

  function automatic logic [CFG_DATA_WIDTH-1:0] random_data();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[CFG_DATA_WIDTH-1:0];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    int v;
    case ($urandom_range(9))
      0: v = $urandom_range(1) ? 32767 : -32768;
      1, 2, 3: v = int'($urandom_range(2047)) - 1024;
      default: v = $urandom_range(65535);
    endcase
    return v[SAMPLE_BITS-1:0];
  endfunction

  // A stable notch most of the time, otherwise anything the fields allow.
  function automatic logic [CFG_DATA_WIDTH-1:0] random_notch();
    longint b1, r, a1, a2;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: begin
        b1 = longint'($urandom_range(2 * COEF_MAX)) - COEF_MAX;
        r  = $urandom_range(65470, 52429);
        a1 = (b1 * r) >>> 16;
        a2 = (r * r) >>> 16;
        return pack_notch(int'(b1), int'(a1), int'(a2));
      end
      6, 7: return random_data();
      8: return pack_notch($urandom_range(1) ? COEF_MAX : COEF_MIN,
                           $urandom_range(1) ? COEF_MAX : COEF_MIN,
                           $urandom_range(1) ? COEF_MAX : COEF_MIN);
      default: return '0;
    endcase
  endfunction

  // Leaves cfg_valid high so that back-to-back writes need no second assignment
  // in one step; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx < IDX_GAIN) begin
      notch_coef[idx] = value;
    end else if (idx == IDX_GAIN) begin
      gain_shadow = value[GAIN_WIDTH-1:0];
    end
  endtask

  task automatic load_random_settings();
    logic [CFG_DATA_WIDTH-1:0] gain_word;
    gain_word = random_data();
    case ($urandom_range(5))
      0: gain_word[GAIN_WIDTH-1:0] = '0;
      1: gain_word[GAIN_WIDTH-1:0] = GAIN_RESET;
      2: gain_word[GAIN_WIDTH-1:0] = '1;
      default: ;
    endcase
    write_reg(IDX_NOTCH1, random_notch());
    write_reg(IDX_NOTCH2, random_notch());
    write_reg(IDX_NOTCH3, random_notch());
    write_reg(IDX_GAIN, gain_word);
    if ($urandom_range(1))
      write_reg(IDX_SPARE_FIRST + CFG_INDEX_WIDTH'($urandom_range(11)), random_data());
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_valid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random(input int count);
    repeat (count) pending_samples.push_back(random_sample());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Coefficients still zero after reset: each section adds the sample from two back.
    foreach (CORNER_SAMPLES[i]) pending_samples.push_back(CORNER_SAMPLES[i]);
    wait_drained();

    // Largest gain with junk above the gain field, spare indexes, and
    // coefficients at their limits so that the sections overflow.
    write_reg(IDX_GAIN, {38'h2A_AAAA_AAAA, 16'hFFFF});
    write_reg(IDX_SPARE_FIRST, random_data());
    write_reg(IDX_SPARE_LAST, random_data());
    write_reg(IDX_NOTCH1, pack_notch(COEF_MIN, COEF_MIN, COEF_MAX));
    write_reg(IDX_NOTCH2, pack_notch(COEF_MAX, COEF_MAX, COEF_MIN));
    write_reg(IDX_NOTCH3, random_data());
    cfg_valid <= 1'b0;
    foreach (OVERLOAD_SAMPLES[i]) pending_samples.push_back(OVERLOAD_SAMPLES[i]);
    wait_drained();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      load_random_settings();
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      // The sender holds off mid-phase until the filter has emptied.
      queue_random(PHASE_SAMPLES / 2);
      wait_drained();
      queue_random(PHASE_SAMPLES - PHASE_SAMPLES / 2);
      wait_drained();
    end

    if (error_count == 0 && expected_samples.size() == 0) begin
      $display("triple_notch_biquad_filter test passed");
    end else begin
      $display("triple_notch_biquad_filter test failed");
    end
    $finish;
  end

  // Sample driver: the prediction is made on the transaction itself.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_samples.push_back(filter_sample(sample_in));
      if (!in_valid || in_ready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid  <= 1'b1;
          sample_in <= pending_samples.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    logic signed [SAMPLE_BITS-1:0] want;
    if (out_valid && out_ready) begin
      result_count++;
      if (expected_samples.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected output sample %0d: %0d", result_count, sample_out);
      end else begin
        want = expected_samples.pop_front();
        if (sample_out !== want) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("output sample %0d: expected %0d, got %0d",
                     result_count, want, sample_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("triple_notch_biquad_filter test failed");
      $finish;
    end
  end

endmodule

FILE: filelist.f
src/tnb_pkg.sv
src/tnb_mul.sv
src/triple_notch_biquad_filter.sv
sim/tb_top.sv
